>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCGI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCGI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fcgi_pkg.sv
// ----------------------------------------------------------------------------
// fcgi_pkg
// Types and constants shared by the FastCGI record deframer.
// ----------------------------------------------------------------------------
package fcgi_pkg;

	localparam int LEN_W       = 31;
	localparam int QUEUE_DEPTH = 2;
	localparam int OUT_DATA_W  = 112;
	localparam int OUT_USER_W  = 4;

	// Record types and BEGIN_REQUEST body codes.
	localparam logic [7:0]  TYPE_BEGIN     = 8'd1;
	localparam logic [7:0]  TYPE_PARAMS    = 8'd4;
	localparam logic [7:0]  TYPE_STDIN     = 8'd5;
	localparam logic [15:0] ROLE_RESPONDER = 16'd1;
	localparam logic [7:0]  FLAG_KEEP      = 8'd1;

	// Byte classes.
	localparam logic [1:0] CLS_HEADER  = 2'd0;
	localparam logic [1:0] CLS_CONTENT = 2'd1;
	localparam logic [1:0] CLS_PADDING = 2'd2;

	// Parameter byte parts.
	localparam logic [1:0] PART_NONE  = 2'd0;
	localparam logic [1:0] PART_LEN   = 2'd1;
	localparam logic [1:0] PART_NAME  = 2'd2;
	localparam logic [1:0] PART_VALUE = 2'd3;

	// A classified byte, passed from the framer to the pair decoder.
	typedef struct packed {
		logic [1:0]  cls;
		logic [7:0]  rec_type;
		logic [15:0] req_id;
		logic [15:0] content_len;
		logic        last;
		logic        is_param;
		logic        param_end;
		logic [7:0]  data;
		logic        keep;
		logic        done;
	} item_t;

	// One finished output beat.
	typedef struct packed {
		logic [1:0]       cls;
		logic [7:0]       rec_type;
		logic [15:0]      req_id;
		logic [15:0]      content_len;
		logic             last;
		logic [1:0]       part;
		logic [LEN_W-1:0] name_size;
		logic [LEN_W-1:0] value_size;
		logic             pair_end;
		logic             keep;
		logic             done;
		logic             error;
	} result_t;

endpackage

>>> hw/rtl/fcgi_front.sv
// ----------------------------------------------------------------------------
// fcgi_front
// Record framer: parses the 8-byte header and classifies every byte.
// ----------------------------------------------------------------------------
module fcgi_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    in_byte,
	output fcgi_pkg::item_t item
);
	import fcgi_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_CONTENT,
		PH_PADDING
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [2:0]  hidx_q, hidx_n;
	logic [7:0]  type_q, type_n;
	logic [15:0] id_q, id_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  pad_q, pad_n;
	logic [15:0] left_q, left_n;
	logic [1:0]  body_q, body_n;
	logic [15:0] role_q, role_n;
	logic        keep_q, keep_n;
	logic        done_q, done_n;
	logic [1:0]  cls;
	logic        last, is_param, param_end;

	always_comb begin
		phase_n   = phase_q;
		hidx_n    = hidx_q;
		type_n    = type_q;
		id_n      = id_q;
		len_n     = len_q;
		pad_n     = pad_q;
		left_n    = left_q;
		body_n    = body_q;
		role_n    = role_q;
		keep_n    = keep_q;
		done_n    = done_q;
		cls       = CLS_HEADER;
		last      = 1'b0;
		is_param  = 1'b0;
		param_end = 1'b0;
		unique case (phase_q)
			PH_CONTENT: begin
				cls = CLS_CONTENT;
				if (type_q == TYPE_BEGIN) begin
					if (body_q < 2'd2) begin
						role_n = {role_q[7:0], in_byte};
					end else if (body_q == 2'd2 && role_q == ROLE_RESPONDER) begin
						keep_n = (in_byte == FLAG_KEEP);
					end
				end
				is_param = (type_q == TYPE_PARAMS);
				// The body index only matters up to the flags byte.
				if (body_q != 2'd3) begin
					body_n = body_q + 2'd1;
				end
				left_n = left_q - 16'd1;
				if (left_n == 16'd0) begin
					if (pad_q != 8'd0) begin
						phase_n = PH_PADDING;
						left_n  = {8'd0, pad_q};
					end else begin
						phase_n = PH_HEADER;
						hidx_n  = 3'd0;
						last    = 1'b1;
					end
				end
			end
			PH_PADDING: begin
				cls    = CLS_PADDING;
				left_n = left_q - 16'd1;
				if (left_n == 16'd0) begin
					phase_n = PH_HEADER;
					hidx_n  = 3'd0;
					last    = 1'b1;
				end
			end
			default: begin
				cls = CLS_HEADER;
				unique case (hidx_q)
					3'd1:       type_n = in_byte;
					3'd2, 3'd3: id_n   = {id_q[7:0], in_byte};
					3'd4, 3'd5: len_n  = {len_q[7:0], in_byte};
					3'd6:       pad_n  = in_byte;
					default:    ;
				endcase
				if (hidx_q == 3'd7) begin
					hidx_n = 3'd0;
					body_n = 2'd0;
					role_n = 16'd0;
					if (len_n == 16'd0) begin
						if (type_n == TYPE_PARAMS) begin
							param_end = 1'b1;
						end else if (type_n == TYPE_STDIN) begin
							done_n = 1'b1;
						end
					end
					if (len_n != 16'd0) begin
						phase_n = PH_CONTENT;
						left_n  = len_n;
					end else if (pad_n != 8'd0) begin
						phase_n = PH_PADDING;
						left_n  = {8'd0, pad_n};
					end else begin
						last = 1'b1;
					end
				end else begin
					hidx_n = hidx_q + 3'd1;
				end
			end
		endcase
	end

	always_comb begin
		item.cls         = cls;
		item.rec_type    = type_n;
		item.req_id      = id_n;
		item.content_len = len_n;
		item.last        = last;
		item.is_param    = is_param;
		item.param_end   = param_end;
		item.data        = in_byte;
		item.keep        = keep_n;
		item.done        = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= 3'd0;
			type_q  <= 8'd0;
			id_q    <= 16'd0;
			len_q   <= 16'd0;
			pad_q   <= 8'd0;
			left_q  <= 16'd0;
			body_q  <= 2'd0;
			role_q  <= 16'd0;
			keep_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			hidx_q  <= hidx_n;
			type_q  <= type_n;
			id_q    <= id_n;
			len_q   <= len_n;
			pad_q   <= pad_n;
			left_q  <= left_n;
			body_q  <= body_n;
			role_q  <= role_n;
			keep_q  <= keep_n;
			done_q  <= done_n;
		end
	end

endmodule

>>> hw/rtl/fcgi_queue.sv
// ----------------------------------------------------------------------------
// fcgi_queue
// Short first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
module fcgi_queue #(
	parameter int DEPTH = fcgi_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fcgi_pkg::item_t push_item,
	output logic            full,
	output logic            valid,
	output fcgi_pkg::item_t head,
	input  logic            pop
);
	import fcgi_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/fcgi_back.sv
// ----------------------------------------------------------------------------
// fcgi_back
// Name-value pair decoder for PARAMS content, with the output register.
// ----------------------------------------------------------------------------
module fcgi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  fcgi_pkg::item_t   item,
	output logic              pop,
	output logic              res_valid,
	output fcgi_pkg::result_t res,
	input  logic              res_ready
);
	import fcgi_pkg::*;

	typedef enum logic [2:0] {
		PP_NAME_LEN0,
		PP_NAME_LENX,
		PP_VAL_LEN0,
		PP_VAL_LENX,
		PP_NAME,
		PP_VALUE
	} pair_phase_t;

	pair_phase_t      phase_q, phase_n;
	logic [1:0]       lbytes_q, lbytes_n;
	logic [LEN_W-1:0] acc_q, acc_n;
	logic [LEN_W-1:0] nlen_q, nlen_n;
	logic [LEN_W-1:0] vlen_q, vlen_n;
	logic [LEN_W-1:0] left_q, left_n;
	logic             err_q, err_n;
	logic             len_done;
	logic [LEN_W-1:0] len_val;
	logic [1:0]       part;
	logic             pend;
	logic             out_valid_q;
	result_t          out_q;

	assign pop       = item_valid && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		phase_n  = phase_q;
		lbytes_n = lbytes_q;
		acc_n    = acc_q;
		nlen_n   = nlen_q;
		vlen_n   = vlen_q;
		left_n   = left_q;
		err_n    = err_q;
		len_done = 1'b0;
		len_val  = '0;
		part     = PART_NONE;
		pend     = 1'b0;
		if (item.param_end) begin
			// An empty PARAMS record closes the stream; any open pair is an error.
			if (phase_q != PP_NAME_LEN0) begin
				err_n = 1'b1;
			end
			phase_n  = PP_NAME_LEN0;
			lbytes_n = 2'd0;
			acc_n    = '0;
			left_n   = '0;
		end else if (item.is_param) begin
			unique case (phase_q)
				PP_NAME_LEN0, PP_VAL_LEN0: begin
					part = PART_LEN;
					if (phase_q == PP_NAME_LEN0) begin
						nlen_n = '0;
						vlen_n = '0;
					end
					if (item.data[7]) begin
						acc_n    = {{(LEN_W-7){1'b0}}, item.data[6:0]};
						lbytes_n = 2'd1;
						phase_n  = (phase_q == PP_NAME_LEN0) ? PP_NAME_LENX : PP_VAL_LENX;
					end else begin
						len_done = 1'b1;
						len_val  = {{(LEN_W-8){1'b0}}, item.data};
					end
				end
				PP_NAME_LENX, PP_VAL_LENX: begin
					part     = PART_LEN;
					acc_n    = {acc_q[LEN_W-9:0], item.data};
					lbytes_n = lbytes_q + 2'd1;
					if (lbytes_n == 2'd0) begin
						len_done = 1'b1;
						len_val  = acc_n;
					end
				end
				PP_NAME: begin
					part   = PART_NAME;
					left_n = left_q - LEN_W'(1);
					if (left_n == '0) begin
						if (vlen_q != '0) begin
							left_n  = vlen_q;
							phase_n = PP_VALUE;
						end else begin
							phase_n = PP_NAME_LEN0;
							pend    = 1'b1;
						end
					end
				end
				default: begin
					part   = PART_VALUE;
					left_n = left_q - LEN_W'(1);
					if (left_n == '0) begin
						phase_n = PP_NAME_LEN0;
						pend    = 1'b1;
					end
				end
			endcase
			if (len_done) begin
				if (phase_q == PP_NAME_LEN0 || phase_q == PP_NAME_LENX) begin
					nlen_n  = len_val;
					phase_n = PP_VAL_LEN0;
				end else begin
					vlen_n = len_val;
					if (nlen_q != '0) begin
						left_n  = nlen_q;
						phase_n = PP_NAME;
					end else if (len_val != '0) begin
						left_n  = len_val;
						phase_n = PP_VALUE;
					end else begin
						phase_n = PP_NAME_LEN0;
						pend    = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PP_NAME_LEN0;
			lbytes_q    <= 2'd0;
			acc_q       <= '0;
			nlen_q      <= '0;
			vlen_q      <= '0;
			left_q      <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (pop) begin
				phase_q               <= phase_n;
				lbytes_q              <= lbytes_n;
				acc_q                 <= acc_n;
				nlen_q                <= nlen_n;
				vlen_q                <= vlen_n;
				left_q                <= left_n;
				err_q                 <= err_n;
				out_valid_q           <= 1'b1;
				out_q.cls             <= item.cls;
				out_q.rec_type        <= item.rec_type;
				out_q.req_id          <= item.req_id;
				out_q.content_len     <= item.content_len;
				out_q.last            <= item.last;
				out_q.part            <= part;
				out_q.name_size       <= nlen_n;
				out_q.value_size      <= vlen_n;
				out_q.pair_end        <= pend;
				out_q.keep            <= item.keep;
				out_q.done            <= item.done;
				out_q.error           <= err_n;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/fastcgi_record_deframer.sv
// ----------------------------------------------------------------------------
// fastcgi_record_deframer: FastCGI request stream tagger and pair decoder.
// A byte accepted is written into the queue, then into the output register,
// and is shown as a result beat from there. Throughput: one byte per cycle while the
// receiver takes beats. Reset: asynchronous, active low, back to the start of a header.
// ----------------------------------------------------------------------------
module fastcgi_record_deframer #(
	parameter int QUEUE_DEPTH = fcgi_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input byte stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
	// Tagged result stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] record_type, [23:8] request_id, [39:24] content_length,
	// [70:40] name_length, [101:71] value_length, [102] pair_end,
	// [103] keep_connection, [104] request_complete, [105] params_error,
	// [111:106] zero.
	output logic [fcgi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [1:0] byte_class, [3:2] param_part.
	output logic [fcgi_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                            m_axis_tlast   // last_of_record
);
	import fcgi_pkg::*;

	// The front end (framer) classifies each beat as it arrives and keeps
	// the record header fields; the back end (pair decoder) walks the PARAMS
	// content and owns the output register. The queue between them lets the
	// framer keep taking beats while a result beat waits downstream.
	logic    take;
	logic    q_full, q_valid, q_pop;
	item_t   front_item, q_head;
	logic    res_valid;
	result_t res;

	assign s_axis_tready = !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;

	fcgi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (s_axis_tdata),
		.item    (front_item)
	);

	fcgi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_item (front_item),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head),
		.pop       (q_pop)
	);

	fcgi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_head),
		.pop        (q_pop),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (m_axis_tready)
	);

	// Pack the result beat onto the output stream.
	assign m_axis_tvalid = res_valid;
	assign m_axis_tlast  = res.last;
	assign m_axis_tuser  = {res.part, res.cls};
	assign m_axis_tdata  = {6'd0, res.error, res.done, res.keep, res.pair_end,
		res.value_size, res.name_size, res.content_len, res.req_id, res.rec_type};

endmodule

>>> hw/rtl/fcgi_checker.sv
// ----------------------------------------------------------------------------
// fcgi_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcgi_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [fcgi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [fcgi_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input logic                            m_axis_tlast
);
	import fcgi_pkg::*;

	// A stalled beat stays put.
	`FCGI_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled beat changed")

	// A header beat can end a record only when the record is empty.
	`FCGI_ASSERT_IMP(a_hdr_last, clk, arst_n, m_axis_tvalid && m_axis_tlast && m_axis_tuser[1:0] == CLS_HEADER, m_axis_tdata[39:24] == 16'd0, "header ended a non-empty record")

	// Pair parts appear only on PARAMS content beats.
	`FCGI_ASSERT_IMP(a_part_ctx, clk, arst_n, m_axis_tvalid && m_axis_tuser[3:2] != PART_NONE, m_axis_tuser[1:0] == CLS_CONTENT && m_axis_tdata[7:0] == TYPE_PARAMS, "pair part outside PARAMS content")

	// A pair can only end on a byte that belongs to a pair.
	`FCGI_ASSERT_IMP(a_pair_end, clk, arst_n, m_axis_tvalid && m_axis_tdata[102], m_axis_tuser[3:2] == PART_LEN || m_axis_tuser[3:2] == PART_NAME || m_axis_tuser[3:2] == PART_VALUE, "pair end on a non-pair byte")

endmodule

bind fastcgi_record_deframer fcgi_checker u_fcgi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: FastCGI record deframer testbench
// Sends FastCGI request byte streams into the deframer: a short directed run,
// then whole random requests. The requests hold BEGIN_REQUEST bodies, PARAMS
// pair streams split across records, odd record types and STDIN records. A
// few of them are broken on purpose. Each byte goes into a byte-order model
// of the tagger, and each result beat is checked field by field against the
// oldest tag that the model has waiting.
// ----------------------------------------------------------------------------
module tb_top;
	import fcgi_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// Header byte positions inside the 8-byte record header.
	localparam logic [2:0] HB_TYPE     = 3'd1;
	localparam logic [2:0] HB_ID_HI    = 3'd2;
	localparam logic [2:0] HB_ID_LO    = 3'd3;
	localparam logic [2:0] HB_LEN_HI   = 3'd4;
	localparam logic [2:0] HB_LEN_LO   = 3'd5;
	localparam logic [2:0] HB_PAD      = 3'd6;
	localparam logic [2:0] HB_RESERVED = 3'd7;

	localparam int unsigned BYTE_TARGET = 1670;
	localparam int unsigned CALM_FROM   = 1400;

	typedef enum logic [1:0] {REC_HEADER, REC_CONTENT, REC_PADDING} rec_phase_e;
	typedef enum logic [2:0] {
		PAIR_NAME_LEN0, PAIR_NAME_LENX, PAIR_VAL_LEN0, PAIR_VAL_LENX, PAIR_NAME, PAIR_VALUE
	} pair_phase_e;

	// Byte-order model of the tagger. It holds its own copy of the framer and
	// pair decoder state and queues one expected tag for every byte taken in.
	class byte_tag_model;
		rec_phase_e       phase;
		logic [2:0]       hdr_idx;
		logic [7:0]       rec_type;
		logic [15:0]      req_id;
		logic [15:0]      content_len;
		logic [7:0]       pad;
		logic [15:0]      left;
		logic [15:0]      body_idx;
		logic [15:0]      role;
		pair_phase_e      pair_ph;
		logic [1:0]       len_bytes;
		logic [LEN_W-1:0] len_acc;
		logic [LEN_W-1:0] name_size;
		logic [LEN_W-1:0] value_size;
		logic [LEN_W-1:0] pair_left;
		logic             keep;
		logic             done;
		logic             err;
		result_t          pending_tags[$];
		int unsigned      tag_errors;

		function new();
			phase       = REC_HEADER;
			hdr_idx     = '0;
			rec_type    = '0;
			req_id      = '0;
			content_len = '0;
			pad         = '0;
			left        = '0;
			body_idx    = '0;
			role        = '0;
			pair_ph     = PAIR_NAME_LEN0;
			len_bytes   = '0;
			len_acc     = '0;
			name_size   = '0;
			value_size  = '0;
			pair_left   = '0;
			keep        = 1'b0;
			done        = 1'b0;
			err         = 1'b0;
			tag_errors  = 0;
		endfunction

		// A whole length has been decoded. Returns 1 when it closes an empty pair.
		function bit finish_length(logic [LEN_W-1:0] len);
			if (pair_ph == PAIR_NAME_LEN0 || pair_ph == PAIR_NAME_LENX) begin
				name_size = len;
				pair_ph   = PAIR_VAL_LEN0;
				return 1'b0;
			end
			value_size = len;
			if (name_size != 0) begin
				pair_left = name_size;
				pair_ph   = PAIR_NAME;
				return 1'b0;
			end
			if (value_size != 0) begin
				pair_left = value_size;
				pair_ph   = PAIR_VALUE;
				return 1'b0;
			end
			pair_ph = PAIR_NAME_LEN0;
			return 1'b1;
		endfunction

		function void param_byte(logic [7:0] b, output logic [1:0] part, output logic pend);
			part = PART_LEN;
			pend = 1'b0;
			case (pair_ph)
				PAIR_NAME_LEN0, PAIR_VAL_LEN0: begin
					if (pair_ph == PAIR_NAME_LEN0) begin
						name_size  = '0;
						value_size = '0;
					end
					if (b[7]) begin
						len_acc   = {24'b0, b[6:0]};
						len_bytes = 2'd1;
						if (pair_ph == PAIR_NAME_LEN0)
							pair_ph = PAIR_NAME_LENX;
						else
							pair_ph = PAIR_VAL_LENX;
					end else begin
						pend = finish_length({23'b0, b});
					end
				end
				PAIR_NAME_LENX, PAIR_VAL_LENX: begin
					len_acc = {len_acc[22:0], b};
					len_bytes++;
					if (len_bytes == 2'd0)
						pend = finish_length(len_acc);
				end
				PAIR_NAME: begin
					part = PART_NAME;
					pair_left--;
					if (pair_left == 0) begin
						if (value_size != 0) begin
							pair_left = value_size;
							pair_ph   = PAIR_VALUE;
						end else begin
							pair_ph = PAIR_NAME_LEN0;
							pend    = 1'b1;
						end
					end
				end
				default: begin
					part = PART_VALUE;
					pair_left--;
					if (pair_left == 0) begin
						pair_ph = PAIR_NAME_LEN0;
						pend    = 1'b1;
					end
				end
			endcase
		endfunction

		function void take_byte(logic [7:0] b);
			result_t r;
			r = '0;
			case (phase)
				REC_CONTENT: begin
					r.cls = CLS_CONTENT;
					if (rec_type == TYPE_BEGIN) begin
						if (body_idx < 2)
							role = {role[7:0], b};
						else if (body_idx == 2 && role == ROLE_RESPONDER)
							keep = (b == FLAG_KEEP);
					end else if (rec_type == TYPE_PARAMS) begin
						param_byte(b, r.part, r.pair_end);
					end
					body_idx++;
					left--;
					if (left == 0) begin
						if (pad != 0) begin
							phase = REC_PADDING;
							left  = {8'b0, pad};
						end else begin
							phase   = REC_HEADER;
							hdr_idx = '0;
							r.last  = 1'b1;
						end
					end
				end
				REC_PADDING: begin
					r.cls = CLS_PADDING;
					left--;
					if (left == 0) begin
						phase   = REC_HEADER;
						hdr_idx = '0;
						r.last  = 1'b1;
					end
				end
				default: begin
					r.cls = CLS_HEADER;
					case (hdr_idx)
						HB_TYPE:              rec_type    = b;
						HB_ID_HI, HB_ID_LO:   req_id      = {req_id[7:0], b};
						HB_LEN_HI, HB_LEN_LO: content_len = {content_len[7:0], b};
						HB_PAD:               pad         = b;
						default: ;
					endcase
					if (hdr_idx == HB_RESERVED) begin
						hdr_idx  = '0;
						body_idx = '0;
						role     = '0;
						// An empty PARAMS record closes the pair stream; an
						// empty STDIN record closes the request.
						if (content_len == 0) begin
							if (rec_type == TYPE_PARAMS) begin
								if (pair_ph != PAIR_NAME_LEN0)
									err = 1'b1;
								pair_ph   = PAIR_NAME_LEN0;
								len_bytes = '0;
								len_acc   = '0;
								pair_left = '0;
							end else if (rec_type == TYPE_STDIN) begin
								done = 1'b1;
							end
						end
						if (content_len != 0) begin
							phase = REC_CONTENT;
							left  = content_len;
						end else if (pad != 0) begin
							phase = REC_PADDING;
							left  = {8'b0, pad};
						end else begin
							r.last = 1'b1;
						end
					end else begin
						hdr_idx++;
					end
				end
			endcase
			r.rec_type    = rec_type;
			r.req_id      = req_id;
			r.content_len = content_len;
			r.name_size   = name_size;
			r.value_size  = value_size;
			r.keep        = keep;
			r.done        = done;
			r.error       = err;
			pending_tags.push_back(r);
		endfunction

		function void cmp_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
			if (exp_v !== got_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, got_v);
				tag_errors++;
			end
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
				logic last);
			result_t e;
			if (pending_tags.size() == 0) begin
				$error("result beat with no byte waiting for it");
				tag_errors++;
				return;
			end
			e = pending_tags.pop_front();
			cmp_field("byte_class", e.cls, user[1:0]);
			cmp_field("param_part", e.part, user[3:2]);
			cmp_field("record_type", e.rec_type, data[7:0]);
			cmp_field("request_id", e.req_id, data[23:8]);
			cmp_field("content_length", e.content_len, data[39:24]);
			cmp_field("name_length", e.name_size, data[70:40]);
			cmp_field("value_length", e.value_size, data[101:71]);
			cmp_field("pair_end", e.pair_end, data[102]);
			cmp_field("keep_connection", e.keep, data[103]);
			cmp_field("request_complete", e.done, data[104]);
			cmp_field("params_error", e.error, data[105]);
			cmp_field("tdata_fill", 0, data[111:106]);
			cmp_field("last_of_record", e.last, last);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	byte_tag_model tags;
	int unsigned   bytes_sent;
	bit            src_idle_on;
	bit            sink_idle_on;

	fastcgi_record_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Both handshakes are sampled here, before the edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tags.take_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				tags.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// Receiver: stalls in short random bursts while idling is allowed.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_idle_on && stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 5);
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// About half the time no padding, otherwise a little, rarely the largest amount.
	function automatic logic [7:0] pick_pad();
		if ($urandom_range(0, 59) == 0)
			return 8'hff;
		if ($urandom_range(0, 1) == 0)
			return 8'd0;
		return 8'($urandom_range(1, 7));
	endfunction

	function automatic int unsigned pick_pair_len();
		int unsigned r;
		r = $urandom_range(0, 39);
		if (r == 0)
			return $urandom_range(128, 140);
		if (r < 8)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	// Short lengths use one byte unless the wide form is chosen at random.
	function automatic void push_length(ref byte_q_t q, input int unsigned len);
		logic [30:0] l;
		l = 31'(len);
		if (len > 127 || $urandom_range(0, 3) == 0) begin
			q.push_back({1'b1, l[30:24]});
			q.push_back(l[23:16]);
			q.push_back(l[15:8]);
			q.push_back(l[7:0]);
		end else begin
			q.push_back(l[7:0]);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_record(input logic [7:0] rtype, input logic [15:0] rid,
			input byte_q_t body, input logic [7:0] pad);
		logic [15:0] blen;
		blen = 16'(body.size());
		send_byte(rand_byte());
		send_byte(rtype);
		send_byte(rid[15:8]);
		send_byte(rid[7:0]);
		send_byte(blen[15:8]);
		send_byte(blen[7:0]);
		send_byte(pad);
		send_byte(rand_byte());
		foreach (body[i])
			send_byte(body[i]);
		repeat (pad)
			send_byte(rand_byte());
	endtask

	// Holds the sender off until every byte sent so far has come back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (tags.pending_tags.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// One request: BEGIN_REQUEST, a PARAMS stream, maybe an odd record, STDIN.
	task automatic send_request();
		byte_q_t     body;
		byte_q_t     stream;
		byte_q_t     none;
		logic [15:0] rid;
		logic [15:0] role;
		int unsigned blen;
		int unsigned nl;
		int unsigned vl;
		int unsigned n;
		int unsigned broken;

		if ($urandom_range(0, 3) == 0)
			rid = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		else
			rid = 16'($urandom_range(0, 65535));

		case ($urandom_range(0, 3))
			0, 1:    role = ROLE_RESPONDER;
			2:       role = 16'($urandom_range(2, 3));
			default: role = 16'($urandom_range(0, 65535));
		endcase
		body = {};
		body.push_back(role[15:8]);
		body.push_back(role[7:0]);
		case ($urandom_range(0, 2))
			0:       body.push_back(8'd0);
			1:       body.push_back(FLAG_KEEP);
			default: body.push_back(rand_byte());
		endcase
		repeat (5)
			body.push_back(rand_byte());
		// A body cut below three bytes leaves the keep-connection flag untouched.
		blen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 8;
		while (body.size() > blen)
			void'(body.pop_back());
		send_record(TYPE_BEGIN, rid, body, pick_pad());

		stream = {};
		repeat ($urandom_range(0, 4)) begin
			nl = pick_pair_len();
			vl = pick_pair_len();
			push_length(stream, nl);
			push_length(stream, vl);
			repeat (nl + vl)
				stream.push_back(rand_byte());
		end
		// Now and then the pair stream is cut short, followed by junk, or
		// ends on a huge declared name length, so the closing empty PARAMS
		// record finds a pair unfinished.
		broken = $urandom_range(0, 11);
		if (broken == 0 && stream.size() > 1) begin
			repeat ($urandom_range(1, stream.size() - 1))
				void'(stream.pop_back());
		end else if (broken == 1) begin
			repeat ($urandom_range(1, 6))
				stream.push_back(rand_byte());
		end else if (broken == 2) begin
			stream.push_back(8'hff);
			repeat (3)
				stream.push_back($urandom_range(0, 1) ? 8'hff : rand_byte());
		end
		while (stream.size() != 0) begin
			n = $urandom_range(1, (stream.size() < 40) ? stream.size() : 40);
			body = {};
			repeat (n)
				body.push_back(stream.pop_front());
			send_record(TYPE_PARAMS, rid, body, pick_pad());
		end
		none = {};
		send_record(TYPE_PARAMS, rid, none, pick_pad());

		// A record of a random type; unless that type is one the tagger decodes, its content is tagged and otherwise ignored.
		if ($urandom_range(0, 2) == 0) begin
			body = {};
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 10);
			repeat (n)
				body.push_back(rand_byte());
			send_record(rand_byte(), rid, body, pick_pad());
		end

		repeat ($urandom_range(0, 2)) begin
			body = {};
			repeat ($urandom_range(1, 12))
				body.push_back(rand_byte());
			send_record(TYPE_STDIN, rid, body, pick_pad());
		end
		send_record(TYPE_STDIN, rid, none, pick_pad());
	endtask

	initial begin
		byte_q_t     body;
		int unsigned req_count;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		m_axis_tready = 1'b0;
		bytes_sent    = 0;
		req_count     = 0;
		src_idle_on   = 1'b1;
		sink_idle_on  = 1'b1;
		tags          = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: an empty record of the largest type and id, which ends on
		// its last header byte, then a three-byte responder body with the
		// keep flag and one padding byte.
		body = {};
		send_record(8'hff, 16'hffff, body, 8'd0);
		body = {8'h00, 8'h01, FLAG_KEEP};
		send_record(TYPE_BEGIN, 16'h0000, body, 8'd1);
		wait_drained();

		while (bytes_sent < BYTE_TARGET) begin
			if (bytes_sent >= CALM_FROM) begin
				src_idle_on  = 1'b0;
				sink_idle_on = 1'b0;
			end
			send_request();
			req_count++;
			if (req_count % 4 == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (tags.pending_tags.size() != 0) begin
			$error("%0d result beats never arrived", tags.pending_tags.size());
			tags.tag_errors++;
		end
		if (tags.tag_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
